// ===== sv/qslerp_pkg.sv =====
// Package for the quaternion slerp block: fixed-point widths, the CORDIC arctangent
// table and the packed types that ride alongside the datapath between units.
// No dependencies.
`default_nettype none

package qslerp_pkg;

    localparam int CW = 34;
    localparam int SW = 31;
    localparam int WW = 33;
    localparam int SQ_STAGES = 32;
    localparam int DIV_BITS = 32;

    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic [31:0] WEIGHT_CAP = 32'h8000_0000;

    localparam logic [31:0] ATAN_HEAD [11] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF
    };

    typedef logic signed [15:0] comp_t;
    typedef logic signed [16:0] comp17_t;
    typedef comp_t [3:0] quad_t;
    typedef comp17_t [3:0] bquad_t;

    typedef struct packed {
        quad_t       a;
        bquad_t      b;
        logic [15:0] t;
        logic        linear;
    } item_t;

    typedef struct packed {
        item_t       item;
        logic [29:0] c;
    } sq_side_t;

    typedef struct packed {
        item_t         item;
        logic [SW-1:0] s;
    } vec_side_t;

    typedef struct packed {
        quad_t         a;
        logic [15:0]   t;
        logic          linear;
        logic [SW-1:0] s;
    } rot_side_t;

    typedef struct packed {
        quad_t       a;
        logic [15:0] t;
        logic        linear;
    } div_side_t;

    typedef struct packed {
        logic [63:0] data;
        logic        user;
    } out_beat_t;

    // Arctangent of 2^-i in Q30, truncated for the deep iterations.
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        if (i < 11)
        begin
            r = CW'(ATAN_HEAD[i]);
        end
        else if (i >= 30)
        begin
            r = '0;
        end
        else
        begin
            r = CW'((64'd1 << (30 - i)) - 64'd1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qslerp_sqrt.sv =====
// Fully pipelined bit-serial square root, one result bit per register stage.
// Depends on qslerp_pkg.
`default_nettype none

module qslerp_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [63:0]               in_v,
    input  wire logic [SIDE_W-1:0]         in_side,
    output logic                           out_valid,
    output logic [qslerp_pkg::SW-1:0]      out_root,
    output logic [SIDE_W-1:0]              out_side
);
    import qslerp_pkg::*;

    logic              v_reg    [SQ_STAGES];
    logic [63:0]       rem_reg  [SQ_STAGES];
    logic [63:0]       root_reg [SQ_STAGES];
    logic [SIDE_W-1:0] side_reg [SQ_STAGES];

    for (genvar i = 0; i < SQ_STAGES; i++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic              vi;
        logic [63:0]       remi;
        logic [63:0]       rooti;
        logic [SIDE_W-1:0] sidei;
        logic [63:0]       trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign vi    = in_valid;
            assign remi  = in_v;
            assign rooti = '0;
            assign sidei = in_side;
        end
        else
        begin : g_rest
            assign vi    = v_reg[i-1];
            assign remi  = rem_reg[i-1];
            assign rooti = root_reg[i-1];
            assign sidei = side_reg[i-1];
        end

        assign trial = rooti + BIT;
        assign ge    = remi >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? remi - trial : remi;
                root_reg[i] <= ge ? (rooti >> 1) + BIT : rooti >> 1;
                side_reg[i] <= sidei;
            end
        end
    end

    assign out_valid = v_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1][SW-1:0];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/qslerp_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per register stage, in vectoring or rotation mode.
// Depends on qslerp_pkg for the word width and the arctangent table.
`default_nettype none

module qslerp_cordic #(
    parameter int ITERS  = 16,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_x,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_y,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_z,
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic signed [qslerp_pkg::CW-1:0]    out_x,
    output logic signed [qslerp_pkg::CW-1:0]    out_y,
    output logic signed [qslerp_pkg::CW-1:0]    out_z,
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    logic                 v_reg    [ITERS];
    logic signed [CW-1:0] x_reg    [ITERS];
    logic signed [CW-1:0] y_reg    [ITERS];
    logic signed [CW-1:0] z_reg    [ITERS];
    logic [SIDE_W-1:0]    side_reg [ITERS];

    for (genvar i = 0; i < ITERS; i++)
    begin : g_stage
        localparam logic signed [CW-1:0] ATAN_I = atan_q30(i);
        logic                 vi;
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        logic [SIDE_W-1:0]    sidei;
        logic                 pos;

        if (i == 0)
        begin : g_first
            assign vi    = in_valid;
            assign xi    = in_x;
            assign yi    = in_y;
            assign zi    = in_z;
            assign sidei = in_side;
        end
        else
        begin : g_rest
            assign vi    = v_reg[i-1];
            assign xi    = x_reg[i-1];
            assign yi    = y_reg[i-1];
            assign zi    = z_reg[i-1];
            assign sidei = side_reg[i-1];
        end

        // Vectoring drives y toward zero, rotation drives z toward zero.
        assign pos = VECTOR ? yi[CW-1] : !zi[CW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= pos ? xi - (yi >>> i) : xi + (yi >>> i);
                y_reg[i]    <= pos ? yi + (xi >>> i) : yi - (xi >>> i);
                z_reg[i]    <= pos ? zi - ATAN_I : zi + ATAN_I;
                side_reg[i] <= sidei;
            end
        end
    end

    assign out_valid = v_reg[ITERS-1];
    assign out_x     = x_reg[ITERS-1];
    assign out_y     = y_reg[ITERS-1];
    assign out_z     = z_reg[ITERS-1];
    assign out_side  = side_reg[ITERS-1];

endmodule

`default_nettype wire

// ===== sv/qslerp_div.sv =====
// Pipelined restoring divider that turns a sine into a weight: magnitude cap, rounding,
// one quotient bit per stage, then cap and sign. Depends on qslerp_pkg.
`default_nettype none

module qslerp_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_num,
    input  wire logic [qslerp_pkg::SW-1:0]        in_den,
    input  wire logic [SIDE_W-1:0]                in_side,
    output logic                                  out_valid,
    output logic signed [qslerp_pkg::WW-1:0]      out_weight,
    output logic [SIDE_W-1:0]                     out_side
);
    import qslerp_pkg::*;

    logic                 v_reg    [DIV_BITS+1];
    logic [61:0]          rem_reg  [DIV_BITS+1];
    logic [SW-1:0]        den_reg  [DIV_BITS+1];
    logic [DIV_BITS-1:0]  q_reg    [DIV_BITS+1];
    logic                 neg_reg  [DIV_BITS+1];
    logic                 ovf_reg  [DIV_BITS+1];
    logic [SIDE_W-1:0]    side_reg [DIV_BITS+1];

    logic                 out_v_reg;
    logic signed [WW-1:0] out_w_reg;
    logic [SIDE_W-1:0]    out_side_reg;

    logic [CW-1:0]        abs_num;
    logic [31:0]          mag;
    logic [61:0]          numer;
    logic [31:0]          q_capped;

    assign abs_num = in_num[CW-1] ? CW'(-in_num) : CW'(in_num);
    assign mag     = (abs_num > CW'(WEIGHT_CAP)) ? WEIGHT_CAP : abs_num[31:0];
    assign numer   = {mag, 30'b0} + 62'(in_den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= numer;
            den_reg[0]  <= in_den;
            q_reg[0]    <= '0;
            neg_reg[0]  <= in_num[CW-1];
            ovf_reg[0]  <= {1'b0, numer} >= {in_den, 32'b0};
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_stage
        localparam int K = DIV_BITS - 1 - j;
        logic [62:0] dk;
        logic        ge;

        assign dk = 63'(den_reg[j]) << K;
        assign ge = {1'b0, rem_reg[j]} >= dk;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? rem_reg[j] - dk[61:0] : rem_reg[j];
                den_reg[j+1]  <= den_reg[j];
                q_reg[j+1]    <= {q_reg[j][DIV_BITS-2:0], ge};
                neg_reg[j+1]  <= neg_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign q_capped = (ovf_reg[DIV_BITS] || (q_reg[DIV_BITS] > WEIGHT_CAP))
                      ? WEIGHT_CAP : q_reg[DIV_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= v_reg[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_w_reg    <= neg_reg[DIV_BITS] ? -$signed({1'b0, q_capped})
                                              : $signed({1'b0, q_capped});
            out_side_reg <= side_reg[DIV_BITS];
        end
    end

    assign out_valid  = out_v_reg;
    assign out_weight = out_w_reg;
    assign out_side   = out_side_reg;

endmodule

`default_nettype wire

// ===== sv/quaternion_slerp.sv =====
// Quaternion slerp top level: dot product front end, square root, angle and sine CORDICs,
// weight dividers, blend and output skid buffer. Depends on qslerp_pkg and all qslerp units.
//
// Usage: an input transfer on s_axis carries both quaternions (Q2.14) and the fraction
// (Q1.15); each one gives exactly one output transfer on m_axis with the blended quaternion
// in tdata and the linear-blend flag in tuser. Results leave in input order.
// The datapath is one pipeline that takes a new item every cycle while s_axis_tready is high.
// It holds 73 + 2 * ANGLE_ITERATIONS register stages (105 by default): 3 front stages, 32
// square root stages, the angle CORDIC, 2 angle split stages, the sine CORDICs, 34 divider
// stages, the blend multipliers and the output register. When the receiver stalls, the output
// register holds its result and one more result lands in the skid register; only then does
// the pipeline freeze and s_axis_tready drop. Nothing is lost or repeated across a stall.
// Reset empties the pipeline and the output and sets close_threshold to 1. close_threshold
// is written through the APB port at address 0; the user must write it only while the block
// is idle, which the block itself does not enforce.
`default_nettype none

module quaternion_slerp #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction (16 bits each)
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x, out_y, out_z, out_w (16 bits each)
    output logic [63:0]       m_axis_tdata,
    // used_linear
    output logic [0:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import qslerp_pkg::*;

    logic [14:0] thr_reg;
    logic        en;

    // Front stage 1: operands and the four products.
    logic        s1_v_reg;
    quad_t       s1_a_reg;
    quad_t       s1_b_reg;
    logic [15:0] s1_t_reg;
    logic signed [31:0] s1_p_reg [4];
    logic [15:0] t_in;

    // Front stage 2: cosine, sign fix, path decision.
    logic        s2_v_reg;
    item_t       s2_item_reg;
    logic [29:0] s2_c_reg;
    logic signed [33:0] cosine;
    logic signed [33:0] cos_abs;
    logic signed [35:0] one_minus;
    logic        cos_neg;
    item_t       s2_item_next;

    // Front stage 3: c squared.
    logic        s3_v_reg;
    sq_side_t    s3_side_reg;
    logic [59:0] s3_csq_reg;
    logic [60:0] radicand;

    logic          sq_valid;
    logic [SW-1:0] sq_root;
    logic [$bits(sq_side_t)-1:0] sq_side_bits;
    sq_side_t      sq_side;
    vec_side_t     vec_in_side;

    logic          vec_valid;
    logic signed [CW-1:0] vec_z;
    logic [$bits(vec_side_t)-1:0] vec_side_bits;
    vec_side_t     vec_side;

    // Angle split stages.
    logic          sm_v_reg;
    vec_side_t     sm_side_reg;
    logic signed [CW-1:0] sm_ang_reg;
    logic signed [50:0]   sm_prod_reg;
    logic signed [50:0]   a1_full;

    logic          ss_v_reg;
    vec_side_t     ss_side_reg;
    logic signed [CW-1:0] ss_a0_reg;
    logic signed [CW-1:0] ss_a1_reg;
    rot_side_t     rot0_in_side;

    logic          rot0_valid;
    logic          rot1_valid;
    logic signed [CW-1:0] sin0;
    logic signed [CW-1:0] sin1;
    logic [$bits(rot_side_t)-1:0] rot0_side_bits;
    logic [$bits(bquad_t)-1:0]    rot1_side_bits;
    rot_side_t     rot0_side;
    div_side_t     div0_in_side;

    logic          div0_valid;
    logic          div1_valid;
    logic signed [WW-1:0] q0;
    logic signed [WW-1:0] q1;
    logic [$bits(div_side_t)-1:0] div0_side_bits;
    logic [$bits(bquad_t)-1:0]    div1_side_bits;
    div_side_t     div0_side;
    bquad_t        div1_b;

    // Blend stage.
    logic          sp_v_reg;
    logic          sp_lin_reg;
    logic signed [49:0] sp_p0_reg [4];
    logic signed [49:0] sp_p1_reg [4];
    logic signed [WW-1:0] w0;
    logic signed [WW-1:0] w1;
    logic [15:0]   t_rest;
    out_beat_t     result;

    // Output register and skid.
    logic          out_v_reg;
    out_beat_t     out_reg;
    logic          skid_v_reg;
    out_beat_t     skid_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 15'd1;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            thr_reg <= pwdata[14:0];
        end
    end

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    // Stage 1.
    assign t_in = (s_axis_tdata[143:128] > 16'd32768) ? 16'd32768 : s_axis_tdata[143:128];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s1_a_reg[k] <= s_axis_tdata[16*k +: 16];
                s1_b_reg[k] <= s_axis_tdata[64 + 16*k +: 16];
                s1_p_reg[k] <= $signed(s_axis_tdata[16*k +: 16])
                             * $signed(s_axis_tdata[64 + 16*k +: 16]);
            end
            s1_t_reg <= t_in;
        end
    end

    // Stage 2.
    assign cosine  = 34'(s1_p_reg[0]) + 34'(s1_p_reg[1]) + 34'(s1_p_reg[2])
                   + 34'(s1_p_reg[3]);
    assign cos_neg = cosine[33];
    assign cos_abs = cos_neg ? -cosine : cosine;
    assign one_minus = 36'sd268435456 - 36'(cos_abs);

    always_comb
    begin
        s2_item_next.a = s1_a_reg;
        for (int k = 0; k < 4; k++)
        begin
            s2_item_next.b[k] = cos_neg ? -17'($signed(s1_b_reg[k]))
                                        : 17'($signed(s1_b_reg[k]));
        end
        s2_item_next.t      = s1_t_reg;
        s2_item_next.linear = !(one_minus > $signed({7'b0, thr_reg, 14'b0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_item_reg <= s2_item_next;
            s2_c_reg    <= {cos_abs[27:0], 2'b00};
        end
    end

    // Stage 3.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg.item <= s2_item_reg;
            s3_side_reg.c    <= s2_c_reg;
            s3_csq_reg       <= s2_c_reg * s2_c_reg;
        end
    end

    assign radicand = (61'd1 << 60) - 61'(s3_csq_reg);

    qslerp_sqrt #(
        .SIDE_W($bits(sq_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s3_v_reg),
        .in_v     (64'(radicand)),
        .in_side  (s3_side_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side_bits)
    );

    assign sq_side          = sq_side_bits;
    assign vec_in_side.item = sq_side.item;
    assign vec_in_side.s    = sq_root;

    qslerp_cordic #(
        .ITERS (ANGLE_ITERATIONS),
        .VECTOR(1'b1),
        .SIDE_W($bits(vec_side_t))
    ) u_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .in_x     ($signed({4'b0, sq_side.c})),
        .in_y     ($signed({3'b0, sq_root})),
        .in_z     ('0),
        .in_side  (vec_in_side),
        .out_valid(vec_valid),
        .out_x    (),
        .out_y    (),
        .out_z    (vec_z),
        .out_side (vec_side_bits)
    );

    assign vec_side = vec_side_bits;

    // Angle times fraction, then the split into the two rotation angles.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_v_reg <= 1'b0;
            ss_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sm_v_reg <= vec_valid;
            ss_v_reg <= sm_v_reg;
        end
    end

    assign a1_full = (sm_prod_reg + 51'sd16384) >>> 15;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_side_reg <= vec_side;
            sm_ang_reg  <= vec_z;
            sm_prod_reg <= vec_z * $signed({1'b0, vec_side.item.t});
            ss_side_reg <= sm_side_reg;
            ss_a1_reg   <= a1_full[CW-1:0];
            ss_a0_reg   <= sm_ang_reg - a1_full[CW-1:0];
        end
    end

    assign rot0_in_side.a      = ss_side_reg.item.a;
    assign rot0_in_side.t      = ss_side_reg.item.t;
    assign rot0_in_side.linear = ss_side_reg.item.linear;
    assign rot0_in_side.s      = ss_side_reg.s;

    qslerp_cordic #(
        .ITERS (ANGLE_ITERATIONS),
        .VECTOR(1'b0),
        .SIDE_W($bits(rot_side_t))
    ) u_sin0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (ss_v_reg),
        .in_x     (INV_GAIN),
        .in_y     ('0),
        .in_z     (ss_a0_reg),
        .in_side  (rot0_in_side),
        .out_valid(rot0_valid),
        .out_x    (),
        .out_y    (sin0),
        .out_z    (),
        .out_side (rot0_side_bits)
    );

    qslerp_cordic #(
        .ITERS (ANGLE_ITERATIONS),
        .VECTOR(1'b0),
        .SIDE_W($bits(bquad_t))
    ) u_sin1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (ss_v_reg),
        .in_x     (INV_GAIN),
        .in_y     ('0),
        .in_z     (ss_a1_reg),
        .in_side  (ss_side_reg.item.b),
        .out_valid(rot1_valid),
        .out_x    (),
        .out_y    (sin1),
        .out_z    (),
        .out_side (rot1_side_bits)
    );

    assign rot0_side           = rot0_side_bits;
    assign div0_in_side.a      = rot0_side.a;
    assign div0_in_side.t      = rot0_side.t;
    assign div0_in_side.linear = rot0_side.linear;

    qslerp_div #(
        .SIDE_W($bits(div_side_t))
    ) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot0_valid),
        .in_num    (sin0),
        .in_den    (rot0_side.s),
        .in_side   (div0_in_side),
        .out_valid (div0_valid),
        .out_weight(q0),
        .out_side  (div0_side_bits)
    );

    qslerp_div #(
        .SIDE_W($bits(bquad_t))
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot1_valid),
        .in_num    (sin1),
        .in_den    (rot0_side.s),
        .in_side   (rot1_side_bits),
        .out_valid (div1_valid),
        .out_weight(q1),
        .out_side  (div1_side_bits)
    );

    assign div0_side = div0_side_bits;
    assign div1_b    = div1_side_bits;

    // Blend: pick the weights and form the eight products.
    assign t_rest = 16'd32768 - div0_side.t;
    assign w0 = div0_side.linear ? $signed({2'b00, t_rest, 15'b0}) : q0;
    assign w1 = div0_side.linear ? $signed({2'b00, div0_side.t, 15'b0}) : q1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sp_v_reg <= div0_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_lin_reg <= div0_side.linear;
            for (int k = 0; k < 4; k++)
            begin
                sp_p0_reg[k] <= w0 * $signed(div0_side.a[k]);
                sp_p1_reg[k] <= w1 * $signed(div1_b[k]);
            end
        end
    end

    always_comb
    begin
        logic signed [50:0] acc;
        logic signed [20:0] r;
        result.user = sp_lin_reg;
        result.data = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = 51'(sp_p0_reg[k]) + 51'(sp_p1_reg[k]) + 51'sd536870912;
            r   = 21'(acc >>> 30);
            if (r > 21'sd32767)
            begin
                result.data[16*k +: 16] = 16'h7FFF;
            end
            else if (r < -21'sd32768)
            begin
                result.data[16*k +: 16] = 16'h8000;
            end
            else
            begin
                result.data[16*k +: 16] = r[15:0];
            end
        end
    end

    // Output register with one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (en && sp_v_reg)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (out_v_reg && m_axis_tready)
        begin
            out_v_reg  <= skid_v_reg;
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && sp_v_reg)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (out_v_reg && m_axis_tready && skid_v_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg.data;
    assign m_axis_tuser  = out_reg.user;

    a_sin_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        rot0_valid == rot1_valid)
        else $error("sine lanes out of step");

    a_div_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        div0_valid == div1_valid)
        else $error("divider lanes out of step");

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without an output transfer pending");

    a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && m_axis_tready) |=> !skid_v_reg && out_v_reg)
        else $error("skid entry not moved to the output");

endmodule

`default_nettype wire

// ===== tb/quaternion_slerp_tb.sv =====
// Self-checking testbench for quaternion_slerp: drives quaternion pairs on the input stream,
// predicts each blended result in fixed point and checks the output stream against it.
// Depends on qslerp_pkg and the quaternion_slerp RTL.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp_tb;
    import qslerp_pkg::*;

    localparam int ITERS = 16;
    localparam logic [2:0] ADDR_CLOSE_THRESHOLD = 3'd0;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic               linear;
    } blend_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    blend_t expected_blends[$];
    logic [14:0] threshold;
    int errors;
    int sent;
    int received;
    int linear_seen;
    int idle_cycles;
    bit hold_off;
    bit sink_random;

    quaternion_slerp #(.ANGLE_ITERATIONS(ITERS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint atan_step(int i);
        if (i < 11)
        begin
            return longint'(ATAN_HEAD[i]);
        end
        if (i >= 30)
        begin
            return 0;
        end
        return (longint'(1) << (30 - i)) - 1;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint nx;
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_step(i);
            end
            else
            begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x;
        longint y;
        longint nx;
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshr(y, i);
                y = y + fshr(x, i);
                z -= atan_step(i);
            end
            else
            begin
                nx = x + fshr(y, i);
                y = y - fshr(x, i);
                z += atan_step(i);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint scaled_weight(longint num, longint unsigned den);
        bit neg;
        longint unsigned mag;
        longint unsigned q;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        if (den == 0)
        begin
            den = 1;
        end
        if (mag > 64'h8000_0000)
        begin
            mag = 64'h8000_0000;
        end
        q = ((mag << 30) + (den >> 1)) / den;
        if (q > 64'h8000_0000)
        begin
            q = 64'h8000_0000;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic blend_t predict_blend(logic [143:0] data);
        longint a[4];
        longint b[4];
        longint cosine;
        longint t;
        longint w0;
        longint w1;
        longint v;
        longint unsigned c;
        longint unsigned s;
        longint ang;
        longint a1;
        logic signed [15:0] res[4];
        blend_t r;
        cosine = 0;
        t = longint'(data[143:128]);
        if (t > 32768)
        begin
            t = 32768;
        end
        for (int k = 0; k < 4; k++)
        begin
            a[k] = longint'($signed(data[16*k +: 16]));
            b[k] = longint'($signed(data[16*(k+4) +: 16]));
            cosine += a[k] * b[k];
        end
        if (cosine < 0)
        begin
            cosine = -cosine;
            for (int k = 0; k < 4; k++)
            begin
                b[k] = -b[k];
            end
        end
        r.linear = !(((longint'(1) << 28) - cosine) > (longint'(threshold) << 14));
        if (r.linear)
        begin
            w0 = (32768 - t) << 15;
            w1 = t << 15;
        end
        else
        begin
            c = longint'(cosine) << 2;
            s = isqrt((64'd1 << 60) - c * c);
            ang = vector_angle(longint'(c), longint'(s));
            a1 = fshr(ang * t + 16384, 15);
            w0 = scaled_weight(rotate_sine(ang - a1), s);
            w1 = scaled_weight(rotate_sine(a1), s);
        end
        for (int k = 0; k < 4; k++)
        begin
            v = fshr(w0 * a[k] + w1 * b[k] + (longint'(1) << 29), 30);
            if (v > 32767)
            begin
                v = 32767;
            end
            if (v < -32768)
            begin
                v = -32768;
            end
            res[k] = v[15:0];
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.w = res[3];
        return r;
    endfunction

    task automatic write_threshold(logic [14:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_CLOSE_THRESHOLD;
        pwdata <= {17'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        threshold = value;
    endtask

    // The sender drops tvalid here, so back-to-back items never see it toggle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_blends.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_pair(logic [143:0] data, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= data;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected_blends.push_back(predict_blend(data));
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [143:0] pack_pair(logic [63:0] from_q, logic [63:0] to_q,
                                               logic [15:0] t);
        return {t, to_q, from_q};
    endfunction

    function automatic logic [15:0] rand_comp();
        return 16'($urandom);
    endfunction

    // A roughly unit quaternion near a random direction; nudge() makes a nearby one for small angles.
    function automatic logic [63:0] unit_like();
        int ax;
        int ay;
        int az;
        int aw;
        real n;
        ax = $urandom_range(0, 32767) - 16384;
        ay = $urandom_range(0, 32767) - 16384;
        az = $urandom_range(0, 32767) - 16384;
        aw = $urandom_range(0, 32767) - 16384;
        n = $sqrt(real'(ax) * ax + real'(ay) * ay + real'(az) * az + real'(aw) * aw) + 1.0;
        return {16'($rtoi(aw * 16384.0 / n)), 16'($rtoi(az * 16384.0 / n)),
                16'($rtoi(ay * 16384.0 / n)), 16'($rtoi(ax * 16384.0 / n))};
    endfunction

    function automatic logic [63:0] nudge(logic [63:0] q, int span);
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
        begin
            r[16*k +: 16] = q[16*k +: 16] + 16'($urandom_range(0, 2 * span) - span);
        end
        return r;
    endfunction

    function automatic logic [143:0] random_pair();
        logic [63:0] f;
        logic [63:0] g;
        int kind;
        logic [15:0] t;
        kind = $urandom_range(0, 9);
        f = unit_like();
        if (kind < 4)
        begin
            g = unit_like();
        end
        else if (kind < 7)
        begin
            g = nudge(f, 1 << $urandom_range(0, 10));
        end
        else if (kind < 8)
        begin
            g = ~nudge(f, 8) + 64'h0001_0001_0001_0001;
        end
        else
        begin
            f = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            g = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end
        t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        return pack_pair(f, g, t);
    endfunction

    task automatic test_directed();
        logic [63:0] ident;
        logic [63:0] quarter;
        ident = {16'sd16384, 48'd0};
        quarter = {16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
        send_pair(pack_pair(ident, ident, 16'd16384), 1'b0);
        send_pair(pack_pair(ident, quarter, 16'd0), 1'b0);
        send_pair(pack_pair(ident, quarter, 16'd32768), 1'b0);
        send_pair(pack_pair(ident, quarter, 16'd16384), 1'b0);
        send_pair(pack_pair(ident, quarter, 16'hFFFF), 1'b0);
        send_pair(pack_pair(ident, quarter, 16'd32769), 1'b0);
        send_pair(pack_pair(ident, {16'h8000, 48'd0}, 16'd8192), 1'b0);
        send_pair(pack_pair(ident, {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'd100), 1'b0);
        send_pair(pack_pair({4{16'h7FFF}}, {4{16'h7FFF}}, 16'd20000), 1'b0);
        send_pair(pack_pair({4{16'h8000}}, {4{16'h7FFF}}, 16'd20000), 1'b0);
        send_pair(pack_pair(ident, {48'd0, 16'sd16384}, 16'd12345), 1'b0);
        send_pair(pack_pair(64'd0, 64'd0, 16'd16384), 1'b0);
        send_pair(pack_pair(ident, {16'sd16383, 16'sd0, 16'sd0, 16'sd181}, 16'd16384), 1'b0);
        send_pair(pack_pair(ident, {-16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 16'd30000),
                  1'b0);
        send_pair(pack_pair({16'sd1, 16'sd2, 16'sd3, 16'sd4},
                            {16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 16'd5), 1'b0);
        wait_idle();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_pair(random_pair(), 1'b1);
        end
    endtask

    task automatic test_thresholds();
        write_threshold(15'd0);
        test_random(60);
        wait_idle();
        write_threshold(15'd16384);
        test_random(40);
        wait_idle();
        write_threshold(15'd200);
        test_random(60);
        wait_idle();
        write_threshold(15'h7FFF);
        test_random(20);
        wait_idle();
        write_threshold(15'd1);
    endtask

    task automatic test_backpressure();
        sink_random = 1'b0;
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++)
        begin
            send_pair(random_pair(), 1'b0);
        end
        wait_idle();
        sink_random = 1'b1;
    endtask

    // Sink: random stalls, with a long hold-off whenever requested.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = sink_random ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 3) == 0)
            begin
                stall = 0;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        blend_t exp_blend;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            received++;
            if (expected_blends.size() == 0)
            begin
                $display("%0t unexpected transfer data=%h user=%b", $time, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_blend = expected_blends.pop_front();
                linear_seen += exp_blend.linear;
                if (m_axis_tdata[15:0] !== exp_blend.x)
                begin
                    $display("%0t out_x expected %h actual %h", $time, exp_blend.x,
                             m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== exp_blend.y)
                begin
                    $display("%0t out_y expected %h actual %h", $time, exp_blend.y,
                             m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== exp_blend.z)
                begin
                    $display("%0t out_z expected %h actual %h", $time, exp_blend.z,
                             m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tdata[63:48] !== exp_blend.w)
                begin
                    $display("%0t out_w expected %h actual %h", $time, exp_blend.w,
                             m_axis_tdata[63:48]);
                    errors++;
                end
                if (m_axis_tuser[0] !== exp_blend.linear)
                begin
                    $display("%0t used_linear expected %b actual %b", $time,
                             exp_blend.linear, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        threshold = 15'd1;
        errors = 0;
        sent = 0;
        received = 0;
        linear_seen = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        sink_random = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(60);
        wait_idle();
        test_thresholds();
        test_backpressure();
        wait_idle();
        $display("Sent %0d quaternion pairs, checked %0d results (%0d on the linear path),",
                 sent, received, linear_seen);
        $display("over five threshold settings with random and long output stalls.");
        if (errors == 0 && expected_blends.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
